@@ src/euler_axes_and_move_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef EULER_AXES_AND_MOVE_MACROS_SVH
`define EULER_AXES_AND_MOVE_MACROS_SVH

// same-cycle implication
`define EAM_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("eam assertion failed");

// next-cycle implication
`define EAM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("eam assertion failed");

`endif

@@ src/eam_pkg.sv @@
`default_nettype none
package eam_pkg;

   localparam int AXIS_FRAC_BITS    = 14;
   localparam int POSITION_WIDTH    = 32;
   localparam int SINCOS_ITERATIONS = 16;

   localparam int FIELD_W   = 16;
   localparam int POS_OUT_W = 32;
   localparam int AXIS_W    = AXIS_FRAC_BITS + 2;
   localparam int MUL_W     = (AXIS_W > FIELD_W) ? AXIS_W : FIELD_W;
   localparam int PROD_W    = 2 * MUL_W;

   localparam int CORDIC_FRAC = 30;
   localparam int CORDIC_W    = 34;
   localparam int ITER_W      = (SINCOS_ITERATIONS > 1) ? $clog2(SINCOS_ITERATIONS) : 1;
   localparam int CORDIC_GAIN = 652032874;

   localparam int TURN_UNITS  = 23040;
   localparam int RED_W       = 15;
   // phase = a*PHASE_STEP + floor((a*PHASE_FIX_SCALE + PHASE_FIX_ADD) / 45)
   localparam int PHASE_STEP      = 186413;
   localparam int PHASE_FIX_SCALE = 23;
   localparam int PHASE_FIX_ADD   = 22;
   localparam int PHASE_FIX_MUL   = 1491309;
   localparam int PHASE_FIX_SH    = 26;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_REDUCE,
      CS_PHASE,
      CS_ITER,
      CS_DONE
   } eam_cstate_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CORD_GO,
      S_CORD_WAIT,
      S_MUL,
      S_POS,
      S_FIN
   } eam_state_type;

   typedef struct packed {
      logic                     done;
      logic signed [AXIS_W-1:0] s;
      logic signed [AXIS_W-1:0] c;
   } eam_sincos_type;

   function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [4:0] k);
      logic signed [CORDIC_W-1:0] r;
      unique case (k)
         5'd0:  r = CORDIC_W'(32'h20000000);
         5'd1:  r = CORDIC_W'(32'h12E4051E);
         5'd2:  r = CORDIC_W'(32'h09FB385B);
         5'd3:  r = CORDIC_W'(32'h051111D4);
         5'd4:  r = CORDIC_W'(32'h028B0D43);
         5'd5:  r = CORDIC_W'(32'h0145D7E1);
         5'd6:  r = CORDIC_W'(32'h00A2F61E);
         5'd7:  r = CORDIC_W'(32'h00517C55);
         5'd8:  r = CORDIC_W'(32'h0028BE53);
         5'd9:  r = CORDIC_W'(32'h00145F2F);
         5'd10: r = CORDIC_W'(32'h000A2F98);
         5'd11: r = CORDIC_W'(32'h000517CC);
         5'd12: r = CORDIC_W'(32'h00028BE6);
         5'd13: r = CORDIC_W'(32'h000145F3);
         5'd14: r = CORDIC_W'(32'h0000A2FA);
         5'd15: r = CORDIC_W'(32'h0000517D);
         5'd16: r = CORDIC_W'(32'h000028BE);
         5'd17: r = CORDIC_W'(32'h0000145F);
         5'd18: r = CORDIC_W'(32'h00000A30);
         5'd19: r = CORDIC_W'(32'h00000518);
         5'd20: r = CORDIC_W'(32'h0000028C);
         5'd21: r = CORDIC_W'(32'h00000146);
         5'd22: r = CORDIC_W'(32'h000000A3);
         5'd23: r = CORDIC_W'(32'h00000051);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [AXIS_W-1:0] clamp_unit(input logic signed [AXIS_W:0] v);
      logic signed [AXIS_W:0] one;
      logic signed [AXIS_W-1:0] r;
      one = (AXIS_W+1)'(1) <<< AXIS_FRAC_BITS;
      if (v > one) begin
         r = AXIS_W'(one);
      end else if (v < -one) begin
         r = AXIS_W'(-one);
      end else begin
         r = AXIS_W'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/eam_cordic.sv @@
`default_nettype none
module eam_cordic (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [15:0]     angle,
   output eam_pkg::eam_sincos_type     result
);
   import eam_pkg::*;

   localparam int SH = CORDIC_FRAC - AXIS_FRAC_BITS;
   localparam int OW = CORDIC_W + 1;

   eam_cstate_type state_ff, state_in;

   logic [RED_W-1:0]           red_ff, red_in;
   logic [31:0]                hi_ff;
   logic [14:0]                lo_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic                       neg_ff;
   logic [ITER_W-1:0]          iter_ff;

   logic signed [16:0]         a17, r1, r2;
   logic [19:0]                fix_n;
   logic [40:0]                fix_prod;
   logic [31:0]                phase;
   logic                       neg_in;
   logic [31:0]                pz;
   logic signed [CORDIC_W-1:0] xs, ys, at;
   logic                       last_iter;

   function automatic logic signed [AXIS_W-1:0] to_axis(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] t;
      logic signed [OW-1:0] one;
      logic signed [AXIS_W-1:0] r;
      t   = (v + (OW'(1) <<< (SH - 1))) >>> SH;
      one = OW'(1) <<< AXIS_FRAC_BITS;
      if (t > one) begin
         r = AXIS_W'(one);
      end else if (t < -one) begin
         r = AXIS_W'(-one);
      end else begin
         r = AXIS_W'(t);
      end
      return r;
   endfunction

   always_comb begin
      a17 = {angle[15], angle};
      if (a17 < 17'sd0) begin
         r1 = a17 + 17'(TURN_UNITS);
      end else if (a17 >= 17'(TURN_UNITS)) begin
         r1 = a17 - 17'(TURN_UNITS);
      end else begin
         r1 = a17;
      end
      r2 = (r1 < 17'sd0) ? r1 + 17'(TURN_UNITS) : r1;
      red_in = RED_W'(r2);
   end

   assign fix_n    = 20'(red_ff) * 20'(PHASE_FIX_SCALE) + 20'(PHASE_FIX_ADD);
   assign fix_prod = 41'(fix_n) * 41'(PHASE_FIX_MUL);
   assign phase    = hi_ff + 32'(lo_ff);
   assign neg_in   = phase[31] ^ phase[30];
   assign pz       = {phase[31] ^ neg_in, phase[30:0]};

   assign xs        = x_ff >>> iter_ff;
   assign ys        = y_ff >>> iter_ff;
   assign at        = atan_entry(5'(iter_ff));
   assign last_iter = (iter_ff == ITER_W'(SINCOS_ITERATIONS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE:   if (start) state_in = CS_REDUCE;
         CS_REDUCE: state_in = CS_PHASE;
         CS_PHASE:  state_in = CS_ITER;
         CS_ITER:   if (last_iter) state_in = CS_DONE;
         CS_DONE:   state_in = CS_IDLE;
         default:   state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      result.done = (state_ff == CS_DONE);
      result.s    = to_axis(neg_ff ? -OW'(y_ff) : OW'(y_ff));
      result.c    = to_axis(neg_ff ? -OW'(x_ff) : OW'(x_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == CS_IDLE && start) begin
         red_ff <= red_in;
      end
      if (state_ff == CS_REDUCE) begin
         hi_ff <= 32'(red_ff) * 32'(PHASE_STEP);
         lo_ff <= fix_prod[PHASE_FIX_SH +: 15];
      end
      if (state_ff == CS_PHASE) begin
         x_ff    <= CORDIC_W'(CORDIC_GAIN);
         y_ff    <= '0;
         z_ff    <= CORDIC_W'($signed(pz));
         neg_ff  <= neg_in;
         iter_ff <= '0;
      end
      if (state_ff == CS_ITER) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
         iter_ff <= iter_ff + ITER_W'(1);
      end
   end

endmodule
`default_nettype wire

@@ src/euler_axes_and_move.sv @@
// Euler axes and move: each item carries pitch, yaw and roll (1/64 degree, any 16-bit
// value wraps modulo 360) and a Q8.8 speed. The block returns the side, up and forward
// axes of the X-Y-Z rotation in Q1.14 and the kept Q16.16 position after moving along
// the forward axis, saturated. One item goes through the accept cycle, three passes
// of the shared CORDIC unit (one iteration per cycle), the axis products and moves on the
// shared multiplier, then one position update and one output load. req_stall is high
// for the whole item; a finished result waits in the output register while the next
// item starts, and the final load waits until that register is free.
`default_nettype none
module euler_axes_and_move (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_pitch_angle,
   input  wire logic signed [15:0] req_yaw_angle,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_speed,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_side_x,
   output logic signed [15:0]      rsp_side_y,
   output logic signed [15:0]      rsp_side_z,
   output logic signed [15:0]      rsp_up_x,
   output logic signed [15:0]      rsp_up_y,
   output logic signed [15:0]      rsp_up_z,
   output logic signed [15:0]      rsp_fwd_x,
   output logic signed [15:0]      rsp_fwd_y,
   output logic signed [15:0]      rsp_fwd_z,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z
);
   import eam_pkg::*;

   localparam int PROD_N    = 14;
   localparam int STEP_LAST = PROD_N + 2;
   localparam int DSH       = AXIS_FRAC_BITS - 8;
   localparam int SUM_W     = ((POSITION_WIDTH > PROD_W) ? POSITION_WIDTH : PROD_W) + 1;
   localparam logic signed [SUM_W-1:0] POS_HI =
      {{(SUM_W - POSITION_WIDTH + 1){1'b0}}, {(POSITION_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

   eam_state_type state_ff, state_in;

   logic signed [15:0]         ang_ff [3];
   logic signed [15:0]         spd_ff;
   logic [1:0]                 aidx_ff;
   logic signed [AXIS_W-1:0]   sin_ff [3];
   logic signed [AXIS_W-1:0]   cos_ff [3];
   logic [4:0]                 step_ff;
   logic signed [AXIS_W-1:0]   prod_ff [PROD_N];
   logic signed [PROD_W-1:0]   delta_ff [3];
   logic signed [POSITION_WIDTH-1:0] place_ff [3];
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       accept, cord_start, cap_en, mul_en, pos_en, out_load;
   eam_sincos_type             sc;
   logic signed [15:0]         cord_angle;

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   full, rnd_axis, rnd_move;
   logic signed [AXIS_W-1:0]   ax [9];
   logic signed [SUM_W-1:0]    psum [3];
   logic signed [SUM_W-1:0]    psat [3];
   logic signed [SUM_W-1:0]    pext [3];

   assign accept     = req_valid && !req_stall;
   assign cord_angle = ang_ff[aidx_ff];

   eam_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cord_start),
      .angle  (cord_angle),
      .result (sc)
   );

   // axis values from sin/cos and products
   always_comb begin
      ax[0] = clamp_unit((AXIS_W+1)'(prod_ff[0]));
      ax[1] = clamp_unit((AXIS_W+1)'(prod_ff[2]) + (AXIS_W+1)'(prod_ff[3]));
      ax[2] = clamp_unit((AXIS_W+1)'(prod_ff[6]) - (AXIS_W+1)'(prod_ff[5]));
      ax[3] = clamp_unit(-(AXIS_W+1)'(prod_ff[7]));
      ax[4] = clamp_unit((AXIS_W+1)'(prod_ff[9]) - (AXIS_W+1)'(prod_ff[8]));
      ax[5] = clamp_unit((AXIS_W+1)'(prod_ff[10]) + (AXIS_W+1)'(prod_ff[11]));
      ax[6] = sin_ff[1];
      ax[7] = clamp_unit(-(AXIS_W+1)'(prod_ff[12]));
      ax[8] = clamp_unit((AXIS_W+1)'(prod_ff[13]));
   end

   // shared multiplier operands: 0..13 axis products, 14..16 moves
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         5'd0:  begin mul_a = MUL_W'(cos_ff[1]);   mul_b = MUL_W'(cos_ff[2]); end
         5'd1:  begin mul_a = MUL_W'(sin_ff[0]);   mul_b = MUL_W'(sin_ff[1]); end
         5'd2:  begin mul_a = MUL_W'(prod_ff[1]);  mul_b = MUL_W'(cos_ff[2]); end
         5'd3:  begin mul_a = MUL_W'(cos_ff[0]);   mul_b = MUL_W'(sin_ff[2]); end
         5'd4:  begin mul_a = MUL_W'(cos_ff[0]);   mul_b = MUL_W'(sin_ff[1]); end
         5'd5:  begin mul_a = MUL_W'(prod_ff[4]);  mul_b = MUL_W'(cos_ff[2]); end
         5'd6:  begin mul_a = MUL_W'(sin_ff[0]);   mul_b = MUL_W'(sin_ff[2]); end
         5'd7:  begin mul_a = MUL_W'(cos_ff[1]);   mul_b = MUL_W'(sin_ff[2]); end
         5'd8:  begin mul_a = MUL_W'(prod_ff[1]);  mul_b = MUL_W'(sin_ff[2]); end
         5'd9:  begin mul_a = MUL_W'(cos_ff[0]);   mul_b = MUL_W'(cos_ff[2]); end
         5'd10: begin mul_a = MUL_W'(prod_ff[4]);  mul_b = MUL_W'(sin_ff[2]); end
         5'd11: begin mul_a = MUL_W'(sin_ff[0]);   mul_b = MUL_W'(cos_ff[2]); end
         5'd12: begin mul_a = MUL_W'(sin_ff[0]);   mul_b = MUL_W'(cos_ff[1]); end
         5'd13: begin mul_a = MUL_W'(cos_ff[0]);   mul_b = MUL_W'(cos_ff[1]); end
         5'd14: begin mul_a = MUL_W'(spd_ff);      mul_b = MUL_W'(ax[6]); end
         5'd15: begin mul_a = MUL_W'(spd_ff);      mul_b = MUL_W'(ax[7]); end
         5'd16: begin mul_a = MUL_W'(spd_ff);      mul_b = MUL_W'(ax[8]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign full     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign rnd_axis = (full + (PROD_W'(1) <<< (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
   assign rnd_move = (full + ((DSH > 0) ? (PROD_W'(1) <<< (DSH - 1)) : PROD_W'(0))) >>> DSH;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         psum[j] = SUM_W'(place_ff[j]) + SUM_W'(delta_ff[j]);
         if (psum[j] > POS_HI) begin
            psat[j] = POS_HI;
         end else if (psum[j] < POS_LO) begin
            psat[j] = POS_LO;
         end else begin
            psat[j] = psum[j];
         end
         pext[j] = SUM_W'(place_ff[j]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (accept) state_in = S_CORD_GO;
         S_CORD_GO:   state_in = S_CORD_WAIT;
         S_CORD_WAIT: if (sc.done) state_in = (aidx_ff == 2'd2) ? S_MUL : S_CORD_GO;
         S_MUL:       if (step_ff == 5'(STEP_LAST)) state_in = S_POS;
         S_POS:       state_in = S_FIN;
         S_FIN:       if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = 1'b1;
      cord_start = 1'b0;
      cap_en     = 1'b0;
      mul_en     = 1'b0;
      pos_en     = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:      req_stall  = 1'b0;
         S_CORD_GO:   cord_start = 1'b1;
         S_CORD_WAIT: cap_en     = sc.done;
         S_MUL:       mul_en     = 1'b1;
         S_POS:       pos_en     = 1'b1;
         S_FIN:       out_load   = !rsp_valid_ff || !rsp_stall;
         default:     req_stall  = 1'b1;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         aidx_ff      <= '0;
         step_ff      <= '0;
         for (int j = 0; j < 3; j++) place_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            aidx_ff <= '0;
            step_ff <= '0;
         end
         if (cap_en) aidx_ff <= aidx_ff + 2'd1;
         if (mul_en) step_ff <= step_ff + 5'd1;
         if (pos_en) begin
            for (int j = 0; j < 3; j++) place_ff[j] <= POSITION_WIDTH'(psat[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ang_ff[0] <= req_pitch_angle;
         ang_ff[1] <= req_yaw_angle;
         ang_ff[2] <= req_roll_angle;
         spd_ff    <= req_speed;
      end
      if (cap_en) begin
         sin_ff[aidx_ff] <= sc.s;
         cos_ff[aidx_ff] <= sc.c;
      end
      if (mul_en) begin
         if (step_ff < 5'(PROD_N)) begin
            prod_ff[step_ff[3:0]] <= AXIS_W'(rnd_axis);
         end else begin
            delta_ff[2'(step_ff - 5'(PROD_N))] <= rnd_move;
         end
      end
      if (out_load) begin
         rsp_side_x <= 16'(ax[0]);
         rsp_side_y <= 16'(ax[1]);
         rsp_side_z <= 16'(ax[2]);
         rsp_up_x   <= 16'(ax[3]);
         rsp_up_y   <= 16'(ax[4]);
         rsp_up_z   <= 16'(ax[5]);
         rsp_fwd_x  <= 16'(ax[6]);
         rsp_fwd_y  <= 16'(ax[7]);
         rsp_fwd_z  <= 16'(ax[8]);
         rsp_pos_x  <= pext[0][POS_OUT_W-1:0];
         rsp_pos_y  <= pext[1][POS_OUT_W-1:0];
         rsp_pos_z  <= pext[2][POS_OUT_W-1:0];
      end
   end

`include "euler_axes_and_move_macros.svh"

   `EAM_ASSERT_NEXT(a_accept_busy, clock, reset, accept, req_stall)
   `EAM_ASSERT_NEXT(a_load_valid, clock, reset, out_load, rsp_valid)
   `EAM_ASSERT_IMPL(a_done_waited, clock, reset, sc.done, state_ff == S_CORD_WAIT)
   `EAM_ASSERT_IMPL(a_step_bound, clock, reset, state_ff == S_MUL, step_ff <= 5'(STEP_LAST))

endmodule
`default_nettype wire

@@ tb/tb_euler_axes_and_move.sv @@
`default_nettype none
module tb_euler_axes_and_move;
   timeunit 1ns;
   timeprecision 1ps;

   import eam_pkg::*;

   localparam int ITEM_COUNT = 1100;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic signed [15:0] roll;
      logic signed [15:0] speed;
   } motion_t;

   typedef struct {
      logic signed [15:0] axis [9];
      logic signed [31:0] pos [3];
   } frame_t;

   typedef struct {
      motion_t m;
      bit      fixed;
      frame_t  f;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_yaw_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_speed = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_side_x, rsp_side_y, rsp_side_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic signed [15:0] rsp_fwd_x, rsp_fwd_y, rsp_fwd_z;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;

   euler_axes_and_move i_dut (.*);

   always #1 clock = ~clock;

   longint place [3];
   frame_t frames_due [$];
   int errors = 0;
   longint cycles = 0;
   bit sending_done = 0;
   bit hold_off = 0;
   int rcv_count = 0;

   string axis_name [9] = '{"side_x", "side_y", "side_z", "up_x", "up_y", "up_z",
                            "fwd_x", "fwd_y", "fwd_z"};
   string pos_name [3] = '{"pos_x", "pos_y", "pos_z"};

   localparam longint ATAN [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   function automatic longint unit_clip(longint v);
      longint one;
      one = longint'(1) << AXIS_FRAC_BITS;
      return (v > one) ? one : ((v < -one) ? -one : v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (longint'(1) << (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
   endfunction

   task automatic angle_trig(input longint ang, output longint s, output longint c);
      longint a, z, x, y, nx, ph;
      bit [31:0] p;
      bit flip;
      int sh;
      a = ang % TURN_UNITS;
      if (a < 0) a += TURN_UNITS;
      ph = ((a << 32) + TURN_UNITS / 2) / TURN_UNITS;
      p = ph[31:0];
      flip = (p + 32'h40000000) >> 31;
      if (flip) p = p + 32'h80000000;
      z = longint'($signed(p));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < SINCOS_ITERATIONS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> (i % 24));
            y = y + (x >>> (i % 24));
            z -= ATAN[i % 24];
         end else begin
            nx = x + (y >>> (i % 24));
            y = y - (x >>> (i % 24));
            z += ATAN[i % 24];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sh = CORDIC_FRAC - AXIS_FRAC_BITS;
      s = unit_clip((y + (longint'(1) << (sh - 1))) >>> sh);
      c = unit_clip((x + (longint'(1) << (sh - 1))) >>> sh);
   endtask

   function automatic longint step_of(longint spd, longint f);
      longint prod;
      int sh;
      prod = spd * f;
      sh = AXIS_FRAC_BITS - 8;
      if (sh == 0) return prod;
      return (prod + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   task automatic predict_frame(input motion_t m, output frame_t f);
      longint sx, cx, sy, cy, sz, cz, hi, lo, r;
      longint v [9];
      angle_trig(m.pitch, sx, cx);
      angle_trig(m.yaw, sy, cy);
      angle_trig(m.roll, sz, cz);
      v[0] = unit_clip(qmul(cy, cz));
      v[1] = unit_clip(qmul(qmul(sx, sy), cz) + qmul(cx, sz));
      v[2] = unit_clip(-qmul(qmul(cx, sy), cz) + qmul(sx, sz));
      v[3] = unit_clip(-qmul(cy, sz));
      v[4] = unit_clip(-qmul(qmul(sx, sy), sz) + qmul(cx, cz));
      v[5] = unit_clip(qmul(qmul(cx, sy), sz) + qmul(sx, cz));
      v[6] = sy;
      v[7] = unit_clip(-qmul(sx, cy));
      v[8] = unit_clip(qmul(cx, cy));
      hi = (longint'(1) << (POSITION_WIDTH - 1)) - 1;
      lo = -hi - 1;
      for (int j = 0; j < 9; j++) f.axis[j] = v[j][15:0];
      for (int j = 0; j < 3; j++) begin
         r = place[j] + step_of(m.speed, v[6 + j]);
         place[j] = (r > hi) ? hi : ((r < lo) ? lo : r);
         f.pos[j] = place[j][31:0];
      end
   endtask

   function automatic motion_t mk(int p, int y, int r, int s);
      motion_t m;
      m.pitch = p;
      m.yaw = y;
      m.roll = r;
      m.speed = s;
      return m;
   endfunction

   function automatic frame_t level_frame(int pos_z);
      frame_t f;
      f.axis = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      f.pos = '{0, 0, pos_z};
      return f;
   endfunction

   task automatic send(input motion_t m, input frame_t fixed_f, input bit fixed);
      frame_t f;
      int gap;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pitch_angle <= m.pitch;
      req_yaw_angle <= m.yaw;
      req_roll_angle <= m.roll;
      req_speed <= m.speed;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame(m, f);
      frames_due.push_back(fixed ? fixed_f : f);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] any_angle();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 180 * 64) * (($urandom_range(0, 1)) ? 1 : -1);
         2: return 90 * 64 * $urandom_range(0, 4) - 180 * 64 + $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, 46080) - 23040;
      endcase
   endfunction

   initial begin
      row_t rows [$];
      frame_t none;
      motion_t m;
      rows.push_back('{mk(0, 0, 0, 0), 1, level_frame(0)});
      rows.push_back('{mk(0, 0, 0, 256), 1, level_frame(256 << 8)});
      rows.push_back('{mk(23040, -23040, 0, -256), 1, level_frame(0)});
      rows.push_back('{mk(0, 0, 0, 16'sh7FFF), 0, none});
      rows.push_back('{mk(0, 0, 0, 16'sh8000), 0, none});
      rows.push_back('{mk(5760, 0, 0, 1000), 0, none});
      rows.push_back('{mk(-5760, 0, 0, 1000), 0, none});
      rows.push_back('{mk(0, 5760, 0, -1000), 0, none});
      rows.push_back('{mk(0, 11520, 0, 500), 0, none});
      rows.push_back('{mk(0, 0, 5760, 500), 0, none});
      rows.push_back('{mk(0, 0, -11520, 500), 0, none});
      rows.push_back('{mk(32767, -32768, 32767, 12345), 0, none});
      rows.push_back('{mk(-32768, 32767, -32768, -12345), 0, none});
      rows.push_back('{mk(23039, -23039, 17280, 77), 0, none});
      rows.push_back('{mk(2880, 2880, 2880, 300), 0, none});
      rows.push_back('{mk(-1, 1, 11519, -1), 0, none});
      rows.push_back('{mk(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0), 0, none});
      rows.push_back('{mk(16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F), 0, none});
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send(rows[i].m, rows[i].f, rows[i].fixed);
      for (int i = 0; i < ITEM_COUNT; i++) begin
         m.pitch = any_angle();
         m.yaw = any_angle();
         m.roll = any_angle();
         case ($urandom_range(0, 4))
            0: m.speed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: m.speed = $urandom_range(0, 63) - 32;
            default: m.speed = $urandom;
         endcase
         if (i >= 600 && i < 700) m.speed = 16'sh7FFF;
         if (i >= 700 && i < 760) m.speed = 16'sh8000;
         if (i == 300) hold_off = 1;
         send(m, none, 0);
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   initial begin
      int wait_n;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 0;
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rcv_count % 200 < 60) begin
            rsp_stall <= 1'b0;
         end else begin
            wait_n = $urandom_range(0, 15);
            if (wait_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      frame_t want;
      logic signed [15:0] got_axis [9];
      logic signed [31:0] got_pos [3];
      if (!reset && rsp_valid && !rsp_stall) begin
         rcv_count++;
         got_axis = '{rsp_side_x, rsp_side_y, rsp_side_z, rsp_up_x, rsp_up_y, rsp_up_z,
                      rsp_fwd_x, rsp_fwd_y, rsp_fwd_z};
         got_pos = '{rsp_pos_x, rsp_pos_y, rsp_pos_z};
         if (frames_due.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            want = frames_due.pop_front();
            for (int j = 0; j < 9; j++)
               if (got_axis[j] !== want.axis[j]) begin
                  $error("%s: expected %0d, got %0d", axis_name[j], want.axis[j],
                         got_axis[j]);
                  errors++;
               end
            for (int j = 0; j < 3; j++)
               if (got_pos[j] !== want.pos[j]) begin
                  $error("%s: expected %0d, got %0d", pos_name[j], want.pos[j],
                         got_pos[j]);
                  errors++;
               end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (sending_done && frames_due.size() == 0) begin
            repeat (200) @(posedge clock);
            if (errors == 0 && frames_due.size() == 0) begin
               $display("DONE: 0 errors");
            end else begin
               $display("DONE: errors detected");
            end
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
